// ----- sv/rtba_pkg.sv -----
// Shared constants for the ray trigger / box acceptance unit.
// Field widths, configuration register indexes and the plane-cut table.
// No dependencies.
package rtba_pkg;

  localparam int unsigned POS_W     = 32;
  localparam int unsigned DIR_W     = 16;
  localparam int unsigned CFG_DW    = 64;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned NUM_CUTS  = 7;

  localparam logic [CFG_IDX_W-1:0] REG_TRIG_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRIG_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TRIG_H = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_X  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_Y  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_Z  = 3'd5;

  // Axis numbering: 0 = x, 1 = y, 2 = z.
  // Cut 0 is the trigger plane, cuts 1..6 are the box faces (z lo/hi, x lo/hi, y lo/hi).
  // CUT_A is the plane normal, CUT_B and CUT_C the two coordinates tested on it.
  localparam int unsigned CUT_A [NUM_CUTS] = '{2, 2, 2, 0, 0, 1, 1};
  localparam int unsigned CUT_B [NUM_CUTS] = '{0, 0, 0, 1, 1, 0, 0};
  localparam int unsigned CUT_C [NUM_CUTS] = '{1, 1, 1, 2, 2, 2, 2};

endpackage

// ----- sv/rtba_ray_if.sv -----
// Ray input channel: valid/ready handshake with start point and direction.
// Depends on rtba_pkg for field widths.
interface rtba_ray_if import rtba_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] start_x;
  logic [POS_W-1:0] start_y;
  logic [POS_W-1:0] start_z;
  logic [DIR_W-1:0] dir_x;
  logic [DIR_W-1:0] dir_y;
  logic [DIR_W-1:0] dir_z;

  modport source (output valid, start_x, start_y, start_z, dir_x, dir_y, dir_z,
                  input ready);
  modport sink (input valid, start_x, start_y, start_z, dir_x, dir_y, dir_z,
                output ready);
endinterface

// ----- sv/rtba_res_if.sv -----
// Result channel: valid/ready handshake carrying the accept flag.
// Depends on rtba_pkg (imported for consistency with the ray channel).
interface rtba_res_if import rtba_pkg::*; ();
  logic valid;
  logic ready;
  logic accepted;

  modport source (output valid, accepted, input ready);
  modport sink (input valid, accepted, output ready);
endinterface

// ----- sv/ray_trigger_box_acceptance_unit.sv -----
// Ray trigger / box acceptance unit: fully pipelined plane-cut tests.
// Depends on rtba_pkg, rtba_ray_if and rtba_res_if.
//
// Usage:
//   Write the six bound/height registers through cfg_we/cfg_index/cfg_data
//   while no ray is in flight. Rays enter on the ray channel (start point
//   Q16.16, direction Q1.15); each ray yields one transaction on the res
//   channel carrying accepted = trigger hit and box crossed.
//   Seven plane cuts run side by side, each with a restoring divider that
//   resolves one quotient bit per stage.
//   Pipeline: the input register loads at the accepting edge of the ray, then
//   COORD_WIDTH + 15 divider stages and the sign, multiply, compare and
//   output stages follow.
//   Throughput: one ray per cycle while the pipe is not stalled (see Stall).
//   Stall: when res holds a transaction that is not taken, the whole pipe
//   holds and ray.ready drops; nothing is lost or repeated.
//   Reset: rst (synchronous) clears all valid bits and the configuration registers to 0.
module ray_trigger_box_acceptance_unit import rtba_pkg::*; #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DW-1:0]    cfg_data,
  rtba_ray_if.sink             ray,
  rtba_res_if.source           res
);

  localparam int CW = COORD_WIDTH;
  localparam int NW = CW + 15;   // dividend magnitude
  localparam int TW = CW + 16;   // signed line parameter
  localparam int PW = TW + 16;   // product t * m
  localparam int XW = TW + 2;    // coordinate at the cut

  logic [CFG_DW-1:0] trig_x, trig_y, box_x, box_y, box_z;
  logic [31:0]       trig_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      trig_x <= '0;
      trig_y <= '0;
      trig_h <= '0;
      box_x  <= '0;
      box_y  <= '0;
      box_z  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TRIG_X: trig_x <= cfg_data;
        REG_TRIG_Y: trig_y <= cfg_data;
        REG_TRIG_H: trig_h <= cfg_data[31:0];
        REG_BOX_X:  box_x  <= cfg_data;
        REG_BOX_Y:  box_y  <= cfg_data;
        REG_BOX_Z:  box_z  <= cfg_data;
        default: ;
      endcase
    end
  end

  function automatic logic signed [CW-1:0] lo_of(input logic [CFG_DW-1:0] r);
    return r[CW-1:0];
  endfunction

  function automatic logic signed [CW-1:0] hi_of(input logic [CFG_DW-1:0] r);
    return r[32+CW-1:32];
  endfunction

  logic signed [CW-1:0] plane_c [NUM_CUTS];
  logic signed [CW-1:0] lo_b [NUM_CUTS];
  logic signed [CW-1:0] hi_b [NUM_CUTS];
  logic signed [CW-1:0] lo_c [NUM_CUTS];
  logic signed [CW-1:0] hi_c [NUM_CUTS];

  always_comb begin
    plane_c[0] = trig_h[CW-1:0];
    plane_c[1] = lo_of(box_z);
    plane_c[2] = hi_of(box_z);
    plane_c[3] = lo_of(box_x);
    plane_c[4] = hi_of(box_x);
    plane_c[5] = lo_of(box_y);
    plane_c[6] = hi_of(box_y);
    lo_b[0] = lo_of(trig_x); hi_b[0] = hi_of(trig_x);
    lo_c[0] = lo_of(trig_y); hi_c[0] = hi_of(trig_y);
    lo_b[1] = lo_of(box_x);  hi_b[1] = hi_of(box_x);
    lo_c[1] = lo_of(box_y);  hi_c[1] = hi_of(box_y);
    lo_b[2] = lo_of(box_x);  hi_b[2] = hi_of(box_x);
    lo_c[2] = lo_of(box_y);  hi_c[2] = hi_of(box_y);
    lo_b[3] = lo_of(box_y);  hi_b[3] = hi_of(box_y);
    lo_c[3] = lo_of(box_z);  hi_c[3] = hi_of(box_z);
    lo_b[4] = lo_of(box_y);  hi_b[4] = hi_of(box_y);
    lo_c[4] = lo_of(box_z);  hi_c[4] = hi_of(box_z);
    lo_b[5] = lo_of(box_x);  hi_b[5] = hi_of(box_x);
    lo_c[5] = lo_of(box_z);  hi_c[5] = hi_of(box_z);
    lo_b[6] = lo_of(box_x);  hi_b[6] = hi_of(box_x);
    lo_c[6] = lo_of(box_z);  hi_c[6] = hi_of(box_z);
  end

  // Global advance: the pipe moves unless the output holds an untaken transaction.
  logic adv;
  assign adv       = !res.valid || res.ready;
  assign ray.ready = adv;

  // Input stage: plane offset magnitude, divisor magnitude and quotient sign.
  logic signed [CW-1:0]    p_in [3];
  logic signed [DIR_W-1:0] m_in [3];
  logic [NW-1:0]           num_in [NUM_CUTS];
  logic [DIR_W-1:0]        den_in [NUM_CUTS];
  logic                    neg_in [NUM_CUTS];
  logic                    hit_in [NUM_CUTS];

  always_comb begin
    logic signed [CW:0]   diff;
    logic        [CW:0]   dmag;
    logic signed [DIR_W-1:0] ma;
    p_in[0] = ray.start_x[CW-1:0];
    p_in[1] = ray.start_y[CW-1:0];
    p_in[2] = ray.start_z[CW-1:0];
    m_in[0] = ray.dir_x;
    m_in[1] = ray.dir_y;
    m_in[2] = ray.dir_z;
    for (int j = 0; j < NUM_CUTS; j++) begin
      ma   = m_in[CUT_A[j]];
      diff = (CW+1)'(plane_c[j]) - (CW+1)'(p_in[CUT_A[j]]);
      dmag = diff[CW] ? -diff : diff;
      num_in[j] = {dmag[CW-1:0], 15'b0};
      den_in[j] = ma[DIR_W-1] ? -ma : ma;
      neg_in[j] = diff[CW] ^ ma[DIR_W-1];
      hit_in[j] = ma != '0;
    end
  end

  // Divider pipe: stage k holds the state after k quotient bits.
  logic [NW-1:0]           dq   [0:NW][NUM_CUTS];
  logic [DIR_W-1:0]        drem [0:NW-1][NUM_CUTS];
  logic [DIR_W-1:0]        dd   [0:NW-1][NUM_CUTS];
  logic                    dneg [0:NW][NUM_CUTS];
  logic                    dhit [0:NW][NUM_CUTS];
  logic signed [CW-1:0]    sp   [0:NW][3];
  logic signed [DIR_W-1:0] sm   [0:NW][3];
  logic                    sv   [0:NW];

  logic [NW-1:0]    q_nx [0:NW-1][NUM_CUTS];
  logic [DIR_W-1:0] r_nx [0:NW-1][NUM_CUTS];

  always_comb begin
    logic [DIR_W:0] sh;
    logic           ge;
    for (int k = 0; k < NW; k++) begin
      for (int j = 0; j < NUM_CUTS; j++) begin
        sh = {drem[k][j], dq[k][j][NW-1]};
        ge = sh >= {1'b0, dd[k][j]};
        r_nx[k][j] = ge ? DIR_W'(sh - {1'b0, dd[k][j]}) : sh[DIR_W-1:0];
        q_nx[k][j] = {dq[k][j][NW-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= NW; k++) sv[k] <= 1'b0;
    end else if (adv) begin
      sv[0] <= ray.valid;
      for (int k = 0; k < NW; k++) sv[k+1] <= sv[k];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int a = 0; a < 3; a++) begin
        sp[0][a] <= p_in[a];
        sm[0][a] <= m_in[a];
      end
      for (int j = 0; j < NUM_CUTS; j++) begin
        dq[0][j]   <= num_in[j];
        drem[0][j] <= '0;
        dd[0][j]   <= den_in[j];
        dneg[0][j] <= neg_in[j];
        dhit[0][j] <= hit_in[j];
      end
      for (int k = 0; k < NW; k++) begin
        for (int a = 0; a < 3; a++) begin
          sp[k+1][a] <= sp[k][a];
          sm[k+1][a] <= sm[k][a];
        end
        for (int j = 0; j < NUM_CUTS; j++) begin
          dq[k+1][j]   <= q_nx[k][j];
          dneg[k+1][j] <= dneg[k][j];
          dhit[k+1][j] <= dhit[k][j];
          if (k < NW - 1) begin
            drem[k+1][j] <= r_nx[k][j];
            dd[k+1][j]   <= dd[k][j];
          end
        end
      end
    end
  end

  // Sign stage: apply the quotient sign (truncation toward zero). The
  // quotient magnitude stays below 2^(TW-1), so no saturation is needed.
  logic signed [TW-1:0]    tt  [NUM_CUTS];
  logic                    th  [NUM_CUTS];
  logic signed [CW-1:0]    tp  [3];
  logic signed [DIR_W-1:0] tm  [3];
  logic                    tv;

  // Multiply stage.
  logic signed [PW-1:0]    mb  [NUM_CUTS];
  logic signed [PW-1:0]    mc  [NUM_CUTS];
  logic                    mh  [NUM_CUTS];
  logic signed [CW-1:0]    mp  [3];
  logic                    mv;

  // Compare stage.
  logic                    cf  [NUM_CUTS];
  logic                    cv;

  logic signed [XW-1:0] xb [NUM_CUTS];
  logic signed [XW-1:0] xc [NUM_CUTS];
  logic                 in_b [NUM_CUTS];
  logic                 in_c [NUM_CUTS];

  always_comb begin
    for (int j = 0; j < NUM_CUTS; j++) begin
      // Arithmetic shift gives the floor of the Q15 product.
      xb[j] = XW'(mp[CUT_B[j]]) + XW'(mb[j] >>> 15);
      xc[j] = XW'(mp[CUT_C[j]]) + XW'(mc[j] >>> 15);
      if (j == 0) begin
        in_b[j] = xb[j] >= XW'(lo_b[j]) && xb[j] <= XW'(hi_b[j]);
        in_c[j] = xc[j] >= XW'(lo_c[j]) && xc[j] <= XW'(hi_c[j]);
      end else begin
        in_b[j] = xb[j] > XW'(lo_b[j]) && xb[j] < XW'(hi_b[j]);
        in_c[j] = xc[j] > XW'(lo_c[j]) && xc[j] < XW'(hi_c[j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tv        <= 1'b0;
      mv        <= 1'b0;
      cv        <= 1'b0;
      res.valid <= 1'b0;
    end else if (adv) begin
      tv        <= sv[NW];
      mv        <= tv;
      cv        <= mv;
      res.valid <= cv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < NUM_CUTS; j++) begin
        tt[j] <= dneg[NW][j] ? -TW'({1'b0, dq[NW][j]}) : TW'({1'b0, dq[NW][j]});
        th[j] <= dhit[NW][j];
        mb[j] <= tt[j] * tm[CUT_B[j]];
        mc[j] <= tt[j] * tm[CUT_C[j]];
        mh[j] <= th[j];
        cf[j] <= mh[j] && in_b[j] && in_c[j];
      end
      for (int a = 0; a < 3; a++) begin
        tp[a] <= sp[NW][a];
        tm[a] <= sm[NW][a];
        mp[a] <= tp[a];
      end
      res.accepted <= cf[0] && (cf[1] || cf[2] || cf[3] || cf[4] || cf[5] || cf[6]);
    end
  end

endmodule
